@@ rtl/core/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and codes for the keyed playback deque
// Holds the request and status codes, the slot entry layout and the command
// that the top level broadcasts along the row of slot cells.
// ----------------------------------------------------------------------------
package kpd_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_PUSH   = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_PLAY   = 2'd3;

   // Status codes carried on rsp_tuser.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   localparam int IdWidth  = 16;
   localparam int TagWidth = 32;

   // One queue slot.
   typedef struct packed {
      logic                mapped;
      logic [IdWidth-1:0]  id;
      logic [TagWidth-1:0] tag;
   } entry_type;

   // Action that every cell performs in the current cycle.
   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_MATCH,
      ACT_APPEND,
      ACT_PUSH,
      ACT_REMOVE,
      ACT_PLAY
   } act_type;

   // Command broadcast to the cell row.
   typedef struct packed {
      act_type             act;
      logic [IdWidth-1:0]  key;
      logic [TagWidth-1:0] tag;
      logic [IdWidth-1:0]  head_id;
   } cell_cmd_type;

endpackage

@@ rtl/core/keyed_playback_deque_core.sv @@
// A result is loaded into the result register by the apply step, which waits while
// an earlier result still sits unaccepted. A new request is taken only after the
// current one has passed the accept cycle, a match pass along the cell row, then
// the shift pass that also loads the result register.
// A new request is taken while an earlier result still waits in its register.
// Reset clears the entry count, the sequencer and the result valid; slots stay.
// ----------------------------------------------------------------------------
// keyed_playback_deque_core: ordered playback queue with keyed operations
// A row of slot cells holds the queue with the head in cell 0. Push front,
// removal by id and play next shift the row; an append writes the tail slot.
// ----------------------------------------------------------------------------
module keyed_playback_deque_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // song_id[15:0], song_tag[47:16]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // head_valid[0], head_id[16:1], head_tag[48:17],
                                    // entry_count[53:49], zero[55:54]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import kpd_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_APPLY} state_type;

   state_type           state_ff, state_in;
   logic [1:0]          req_ff;
   logic [IdWidth-1:0]  key_ff;
   logic [TagWidth-1:0] tag_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic                found_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff, status_in;
   logic                rsp_hvalid_ff;
   logic [IdWidth-1:0]  rsp_id_ff;
   logic [TagWidth-1:0] rsp_tag_ff;
   logic [4:0]          rsp_count_ff;

   cell_cmd_type        cmd;
   entry_type           new_ent;
   entry_type           ent_q [DEPTH];
   entry_type           ent_d [DEPTH];
   logic [DEPTH:0]      seen;
   logic                full;
   logic                accept;
   logic                apply_go;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));

   // The apply step runs once the result register is free or being drained.
   assign apply_go   = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);

   assign new_ent.mapped = 1'b1;
   assign new_ent.id     = key_ff;
   assign new_ent.tag    = tag_ff;

   // Decide the action, status and new count for the pending request.
   always_comb begin
      cmd.key     = key_ff;
      cmd.tag     = tag_ff;
      cmd.head_id = ent_q[0].id;
      cmd.act     = ACT_HOLD;
      status_in   = STAT_OK;
      count_in    = count_ff;
      state_in    = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.act  = ACT_MATCH;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in = ST_IDLE;
               unique case (req_ff)
                  REQ_APPEND: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd.act  = ACT_APPEND;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_PUSH: begin
                     if (!found_ff && full) begin
                        status_in = STAT_FULL;
                     end else begin
                        cmd.act = ACT_PUSH;
                        if (!found_ff) begin
                           count_in = count_ff + CW'(1);
                        end
                     end
                  end
                  REQ_REMOVE: begin
                     if (!found_ff) begin
                        status_in = STAT_NOTFOUND;
                     end else begin
                        cmd.act  = ACT_REMOVE;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        cmd.act  = ACT_PLAY;
                        count_in = count_ff - CW'(1);
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Row of slot cells; cell 0 is the head.
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_ent, right_ent;
      logic      in_use, is_tail;

      assign in_use  = (CW'(i) < count_ff);
      assign is_tail = (CW'(i) == count_ff);

      if (i == 0) begin : g_first
         assign left_ent = new_ent;
      end else begin : g_mid_left
         assign left_ent = ent_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_ent = ent_q[i];
      end else begin : g_mid_right
         assign right_ent = ent_q[i+1];
      end

      kpd_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .in_use    (in_use),
         .is_tail   (is_tail),
         .seen_in   (seen[i]),
         .seen_out  (seen[i+1]),
         .left_ent  (left_ent),
         .right_ent (right_ent),
         .ent_q     (ent_q[i]),
         .ent_d     (ent_d[i])
      );
   end

   // Sequencer, request capture and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         req_ff <= req_tuser;
         key_ff <= req_tdata[15:0];
         tag_ff <= req_tdata[47:16];
      end

      if (state_ff == ST_MATCH) begin
         found_ff <= seen[DEPTH];
      end

      if (apply_go) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= 5'(count_in);
         if (count_in == '0) begin
            rsp_hvalid_ff <= 1'b0;
            rsp_id_ff     <= '0;
            rsp_tag_ff    <= '0;
         end else begin
            rsp_hvalid_ff <= 1'b1;
            rsp_id_ff     <= ent_d[0].id;
            rsp_tag_ff    <= ent_d[0].tag;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_tag_ff, rsp_id_ff, rsp_hvalid_ff};

endmodule

@@ rtl/core/kpd_cell.sv @@
// ----------------------------------------------------------------------------
// kpd_cell: one slot of the playback deque
// Holds one entry, takes part in the match chain that locates the mapped entry
// with the request id, and shifts toward either neighbor when told to.
// ----------------------------------------------------------------------------
module kpd_cell (
   input  logic                  clock,
   input  kpd_pkg::cell_cmd_type cmd,
   input  logic                  in_use,
   input  logic                  is_tail,
   input  logic                  seen_in,
   output logic                  seen_out,
   input  kpd_pkg::entry_type    left_ent,
   input  kpd_pkg::entry_type    right_ent,
   output kpd_pkg::entry_type    ent_q,
   output kpd_pkg::entry_type    ent_d
);
   import kpd_pkg::*;

   entry_type ent_ff, ent_in;
   logic      seen_in_ff, seen_in_in;
   logic      take_ff, take_in;
   logic      hit;

   // A hit is a live, mapped slot that holds the request id.
   assign hit      = in_use & ent_ff.mapped & (ent_ff.id == cmd.key);
   assign seen_out = seen_in | hit;

   // The match phase records where this slot lies relative to the hit.
   always_comb begin
      seen_in_in = seen_in_ff;
      take_in    = take_ff;
      if (cmd.act == ACT_MATCH) begin
         seen_in_in = seen_in;
         take_in    = seen_out;
      end
   end

   // Next slot contents for each action.
   always_comb begin
      ent_in = ent_ff;
      unique case (cmd.act)
         ACT_APPEND: begin
            if (ent_ff.id == cmd.key) begin
               ent_in.mapped = 1'b0;
            end
            if (is_tail) begin
               ent_in.mapped = 1'b1;
               ent_in.id     = cmd.key;
               ent_in.tag    = cmd.tag;
            end
         end
         ACT_PUSH: begin
            // Slots up to and including the removed one move one step back.
            if (!seen_in_ff) begin
               ent_in = left_ent;
            end
         end
         ACT_REMOVE: begin
            // Slots from the removed one on move one step forward.
            if (take_ff) begin
               ent_in = right_ent;
            end
         end
         ACT_PLAY: begin
            ent_in        = right_ent;
            ent_in.mapped = right_ent.mapped & (right_ent.id != cmd.head_id);
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff     <= ent_in;
      seen_in_ff <= seen_in_in;
      take_ff    <= take_in;
   end

   assign ent_q = ent_ff;
   assign ent_d = ent_in;

endmodule
